// ----- design/rma_pkg.sv -----
package rma_pkg;

  // Field and register widths
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ACT_W     = 3;
  localparam int unsigned TWR_W     = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned KLEN_W    = 6;

  // Pipeline shape: two remainder bits per stage, Barrett chain is eight stages
  localparam int unsigned DIV_STEPS  = DATA_W / 2;
  localparam int unsigned MUL_STAGES = 8;
  localparam int unsigned LAST_STAGE = DIV_STEPS;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ADD  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SUB  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MUL  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RED  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_LIFT = 3'd4;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MU_BASE      = 3'd4;

  localparam logic [DATA_W-1:0] MODULUS_RST = 32'd2;
  localparam logic [DATA_W+1:0] MODULUS3_RST = 34'd6;
  localparam logic [KLEN_W-1:0] KLEN_RST = 6'd2;

  typedef logic [DATA_W-1:0]   word_t;
  typedef logic [2*DATA_W-1:0] dword_t;
  typedef logic [DATA_W+1:0]   word3_t;
  typedef logic [KLEN_W-1:0]   klen_t;
  typedef logic [LAST_STAGE:0] stage_en_t;

  // Operands and tower constants of one item after the tower lookup
  typedef struct packed {
    word_t          a;
    word_t          b;
    word_t          q;
    word3_t         q3;
    logic [DATA_W:0] mu;
    klen_t          klen;
  } item_t;

  // Stage enables and the valid bit of the last stage
  typedef struct packed {
    stage_en_t en;
    logic      last_valid;
  } pipe_ctl_t;

  function automatic klen_t bit_length(input word_t v);
    klen_t n;
    n = '0;
    for (int i = 0; i < DATA_W; i++) begin
      if (v[i]) begin
        n = klen_t'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

// ----- design/rma_in_if.sv -----
interface rma_in_if;
  logic                        valid;
  logic                        ready;
  logic [rma_pkg::ACT_W-1:0]   action;
  logic [rma_pkg::TWR_W-1:0]   tower;
  logic [rma_pkg::DATA_W-1:0]  operand_a;
  logic [rma_pkg::DATA_W-1:0]  operand_b;

  modport source (output valid, action, tower, operand_a, operand_b, input ready);
  modport sink   (input valid, action, tower, operand_a, operand_b, output ready);
endinterface

// ----- design/rma_out_if.sv -----
interface rma_out_if;
  logic                        valid;
  logic                        ready;
  logic [rma_pkg::DATA_W-1:0]  residue;

  modport source (output valid, residue, input ready);
  modport sink   (input valid, residue, output ready);
endinterface

// ----- design/rma_ctrl.sv -----
module rma_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               out_ready,
  output rma_pkg::pipe_ctl_t ctl
);

  logic [rma_pkg::LAST_STAGE:0] vld_r;
  logic [rma_pkg::LAST_STAGE:0] vld_nxt;
  rma_pkg::stage_en_t           en;

  // A stage loads unless it and every stage after it hold a beat and the sink stalls
  for (genvar j = 0; j <= rma_pkg::LAST_STAGE; j++) begin : g_en
    assign en[j] = out_ready || !(&vld_r[rma_pkg::LAST_STAGE:j]);
  end

  // Advance valid bits with the data, squeezing out bubbles
  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int j = 1; j <= rma_pkg::LAST_STAGE; j++) begin
      if (en[j]) begin
        vld_nxt[j] = vld_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctl.en         = en;
  assign ctl.last_valid = vld_r[rma_pkg::LAST_STAGE];

endmodule

// ----- design/rma_barrett.sv -----
module rma_barrett (
  input  logic               clk,
  input  rma_pkg::stage_en_t en,
  input  rma_pkg::item_t     item,
  output rma_pkg::word_t     mul_res
);

  // Stage 1: full product
  rma_pkg::dword_t           z1_r;
  rma_pkg::word_t            q1_r;
  logic [rma_pkg::DATA_W:0]  mu1_r;
  rma_pkg::klen_t            k1_r;
  // Stage 2: product shifted down by k-1
  logic [2*rma_pkg::DATA_W-2:0] t2_r;
  rma_pkg::dword_t           z2_r;
  rma_pkg::word_t            q2_r;
  logic [rma_pkg::DATA_W:0]  mu2_r;
  rma_pkg::klen_t            k2_r;
  // Stage 3: partial products of t*mu
  rma_pkg::dword_t           plo3_r;
  logic [2*rma_pkg::DATA_W-2:0] phi3_r;
  logic [2*rma_pkg::DATA_W-2:0] tadd3_r;
  rma_pkg::dword_t           z3_r;
  rma_pkg::word_t            q3_r;
  rma_pkg::klen_t            k3_r;
  // Stage 4: t*mu summed
  logic [3*rma_pkg::DATA_W-1:0] full4_r;
  rma_pkg::dword_t           z4_r;
  rma_pkg::word_t            q4_r;
  rma_pkg::klen_t            k4_r;
  // Stage 5: quotient estimate
  rma_pkg::dword_t           est5_r;
  rma_pkg::dword_t           z5_r;
  rma_pkg::word_t            q5_r;
  // Stage 6: partial products of est*q
  rma_pkg::dword_t           mlo6_r;
  rma_pkg::word_t            mhi6_r;
  rma_pkg::dword_t           z6_r;
  rma_pkg::word_t            q6_r;
  // Stage 7: wrapped remainder
  rma_pkg::dword_t           r7_r;
  rma_pkg::word_t            q7_r;
  rma_pkg::word3_t           q37_r;
  // Stage 8: corrected residue
  rma_pkg::word_t            res8_r;

  rma_pkg::klen_t               sh_t;
  rma_pkg::klen_t               sh_e;
  logic [2*rma_pkg::DATA_W-2:0] t_nxt;
  rma_pkg::dword_t              plo_nxt;
  logic [2*rma_pkg::DATA_W-2:0] phi_nxt;
  logic [3*rma_pkg::DATA_W-1:0] full_nxt;
  rma_pkg::dword_t              est_nxt;
  rma_pkg::dword_t              mlo_nxt;
  rma_pkg::word_t               mhi_nxt;
  rma_pkg::dword_t              r_nxt;
  logic [2*rma_pkg::DATA_W:0]   d1;
  logic [2*rma_pkg::DATA_W:0]   d2;
  logic [2*rma_pkg::DATA_W:0]   d3;
  rma_pkg::word_t               res_nxt;

  assign sh_t     = k1_r - rma_pkg::klen_t'(1);
  assign t_nxt    = (2*rma_pkg::DATA_W-1)'(z1_r >> sh_t);
  assign plo_nxt  = rma_pkg::dword_t'(t2_r[rma_pkg::DATA_W-1:0])
                  * rma_pkg::dword_t'(mu2_r[rma_pkg::DATA_W-1:0]);
  assign phi_nxt  = (2*rma_pkg::DATA_W-1)'(t2_r[2*rma_pkg::DATA_W-2:rma_pkg::DATA_W])
                  * (2*rma_pkg::DATA_W-1)'(mu2_r[rma_pkg::DATA_W-1:0]);
  assign full_nxt = (3*rma_pkg::DATA_W)'(plo3_r)
                  + {1'b0, phi3_r, {rma_pkg::DATA_W{1'b0}}}
                  + {1'b0, tadd3_r, {rma_pkg::DATA_W{1'b0}}};
  assign sh_e     = k4_r + rma_pkg::klen_t'(1);
  assign est_nxt  = (2*rma_pkg::DATA_W)'(full4_r >> sh_e);
  assign mlo_nxt  = rma_pkg::dword_t'(est5_r[rma_pkg::DATA_W-1:0])
                  * rma_pkg::dword_t'(q5_r);
  assign mhi_nxt  = est5_r[2*rma_pkg::DATA_W-1:rma_pkg::DATA_W] * q5_r;
  assign r_nxt    = z6_r - mlo6_r - {mhi6_r, {rma_pkg::DATA_W{1'b0}}};

  // Up to three subtractions of q, tried in parallel against q, 2q and 3q
  assign d1 = {1'b0, r7_r} - (2*rma_pkg::DATA_W+1)'(q7_r);
  assign d2 = {1'b0, r7_r} - (2*rma_pkg::DATA_W+1)'({q7_r, 1'b0});
  assign d3 = {1'b0, r7_r} - (2*rma_pkg::DATA_W+1)'(q37_r);

  always_comb begin
    if (!d3[2*rma_pkg::DATA_W]) begin
      res_nxt = d3[rma_pkg::DATA_W-1:0];
    end else if (!d2[2*rma_pkg::DATA_W]) begin
      res_nxt = d2[rma_pkg::DATA_W-1:0];
    end else if (!d1[2*rma_pkg::DATA_W]) begin
      res_nxt = d1[rma_pkg::DATA_W-1:0];
    end else begin
      res_nxt = r7_r[rma_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      z1_r  <= rma_pkg::dword_t'(item.a) * rma_pkg::dword_t'(item.b);
      q1_r  <= item.q;
      mu1_r <= item.mu;
      k1_r  <= item.klen;
    end
    if (en[2]) begin
      t2_r  <= t_nxt;
      z2_r  <= z1_r;
      q2_r  <= q1_r;
      mu2_r <= mu1_r;
      k2_r  <= k1_r;
    end
    if (en[3]) begin
      plo3_r  <= plo_nxt;
      phi3_r  <= phi_nxt;
      tadd3_r <= mu2_r[rma_pkg::DATA_W] ? t2_r : '0;
      z3_r    <= z2_r;
      q3_r    <= q2_r;
      k3_r    <= k2_r;
    end
    if (en[4]) begin
      full4_r <= full_nxt;
      z4_r    <= z3_r;
      q4_r    <= q3_r;
      k4_r    <= k3_r;
    end
    if (en[5]) begin
      est5_r <= est_nxt;
      z5_r   <= z4_r;
      q5_r   <= q4_r;
    end
    if (en[6]) begin
      mlo6_r <= mlo_nxt;
      mhi6_r <= mhi_nxt;
      z6_r   <= z5_r;
      q6_r   <= q5_r;
    end
    if (en[7]) begin
      r7_r  <= r_nxt;
      q7_r  <= q6_r;
      q37_r <= rma_pkg::word3_t'(q6_r) + rma_pkg::word3_t'({q6_r, 1'b0});
    end
    if (en[rma_pkg::MUL_STAGES]) begin
      res8_r <= res_nxt;
    end
  end

  assign mul_res = res8_r;

endmodule

// ----- design/rma_div.sv -----
module rma_div (
  input  logic               clk,
  input  rma_pkg::stage_en_t en,
  input  rma_pkg::item_t     item,
  output rma_pkg::word_t     rem
);

  localparam int unsigned N = rma_pkg::DIV_STEPS;

  rma_pkg::word_t  rem_r [1:N];
  rma_pkg::word_t  dvd_r [1:N-1];
  rma_pkg::word_t  dq_r  [1:N-1];
  rma_pkg::word3_t dq3_r [1:N-1];

  // One radix-4 remainder step per stage, most significant dividend bits first
  for (genvar j = 1; j <= N; j++) begin : g_step
    rma_pkg::word_t          rem_in;
    rma_pkg::word_t          dvd_in;
    rma_pkg::word_t          q_in;
    rma_pkg::word3_t         q3_in;
    rma_pkg::word3_t         x;
    logic [rma_pkg::DATA_W+2:0] d1;
    logic [rma_pkg::DATA_W+2:0] d2;
    logic [rma_pkg::DATA_W+2:0] d3;
    rma_pkg::word_t          rem_nxt;

    if (j == 1) begin : g_first
      assign rem_in = '0;
      assign dvd_in = item.a;
      assign q_in   = item.q;
      assign q3_in  = item.q3;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign dvd_in = dvd_r[j-1];
      assign q_in   = dq_r[j-1];
      assign q3_in  = dq3_r[j-1];
    end

    assign x  = {rem_in, dvd_in[rma_pkg::DATA_W-1:rma_pkg::DATA_W-2]};
    assign d1 = {1'b0, x} - (rma_pkg::DATA_W+3)'(q_in);
    assign d2 = {1'b0, x} - (rma_pkg::DATA_W+3)'({q_in, 1'b0});
    assign d3 = {1'b0, x} - (rma_pkg::DATA_W+3)'(q3_in);

    always_comb begin
      if (!d3[rma_pkg::DATA_W+2]) begin
        rem_nxt = d3[rma_pkg::DATA_W-1:0];
      end else if (!d2[rma_pkg::DATA_W+2]) begin
        rem_nxt = d2[rma_pkg::DATA_W-1:0];
      end else if (!d1[rma_pkg::DATA_W+2]) begin
        rem_nxt = d1[rma_pkg::DATA_W-1:0];
      end else begin
        rem_nxt = x[rma_pkg::DATA_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j] <= rem_nxt;
      end
    end

    // Carry the dividend and divisor on to the next step
    if (j < N) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[j]) begin
          dvd_r[j] <= {dvd_in[rma_pkg::DATA_W-3:0], 2'b00};
          dq_r[j]  <= q_in;
          dq3_r[j] <= q3_in;
        end
      end
    end
  end

  assign rem = rem_r[N];

endmodule

// ----- design/rns_modular_elementwise_alu_core.sv -----
// Throughput: one beat per cycle while the output is not stalled; a stall
// holds only the trailing run of full stages, so bubbles are squeezed out
// and input is still taken unless every stage is full. The depth is set by
// the remainder unit, two bits of the dividend per stage.
// Reset (rst_n low, synchronous): pipeline emptied, moduli back to 2, mu to 0.
module rns_modular_elementwise_alu_core #(
  parameter int unsigned TOWERS = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  rma_in_if.sink                             in_ch,
  rma_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [rma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rma_pkg::DATA_W-1:0]         cfg_data
);

  localparam int unsigned LAST = rma_pkg::LAST_STAGE;

  typedef enum logic [1:0] {
    SEL_SIDE = 2'd0,
    SEL_MUL  = 2'd1,
    SEL_RED  = 2'd2
  } sel_t;

  // Tower constants
  rma_pkg::word_t  mod_r  [TOWERS];
  rma_pkg::word3_t mod3_r [TOWERS];
  rma_pkg::klen_t  klen_r [TOWERS];
  rma_pkg::word_t  mu_r   [TOWERS];

  rma_pkg::pipe_ctl_t ctl;
  rma_pkg::item_t     lk;
  logic               lk_zero;
  logic               hit;

  rma_pkg::item_t            itm_s0_r;
  logic [rma_pkg::ACT_W-1:0] act_s0_r;
  logic                      zero_s0_r;

  rma_pkg::word_t res_r [1:LAST];
  sel_t           sel_r [1:LAST];

  rma_pkg::word_t mul_res;
  rma_pkg::word_t rem;

  logic [rma_pkg::DATA_W+1:0] sum_q;
  logic [rma_pkg::DATA_W:0]   sum;
  logic [rma_pkg::DATA_W:0]   diff;
  rma_pkg::word_t             side_nxt;
  sel_t                       sel_nxt;

  // Write tower constants and their derived forms
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOWERS; i++) begin
        mod_r[i]  <= rma_pkg::MODULUS_RST;
        mod3_r[i] <= rma_pkg::MODULUS3_RST;
        klen_r[i] <= rma_pkg::KLEN_RST;
        mu_r[i]   <= '0;
      end
    end else if (cfg_we) begin
      for (int i = 0; i < TOWERS; i++) begin
        if (cfg_index == rma_pkg::REG_MODULUS_BASE + rma_pkg::CFG_IDX_W'(i)) begin
          mod_r[i]  <= cfg_data;
          mod3_r[i] <= rma_pkg::word3_t'(cfg_data) + rma_pkg::word3_t'({cfg_data, 1'b0});
          klen_r[i] <= rma_pkg::bit_length(cfg_data);
        end
        if (cfg_index == rma_pkg::REG_MU_BASE + rma_pkg::CFG_IDX_W'(i)) begin
          mu_r[i] <= cfg_data;
        end
      end
    end
  end

  // Look up the tower of the incoming beat
  always_comb begin
    lk   = '0;
    hit  = 1'b0;
    lk.a = in_ch.operand_a;
    lk.b = in_ch.operand_b;
    for (int i = 0; i < TOWERS; i++) begin
      if (in_ch.tower == rma_pkg::TWR_W'(i)) begin
        hit     = 1'b1;
        lk.q    = mod_r[i];
        lk.q3   = mod3_r[i];
        lk.klen = klen_r[i];
        lk.mu   = {mod_r[i][rma_pkg::DATA_W-1], mu_r[i]};
      end
    end
    lk_zero = !hit || (lk.q[rma_pkg::DATA_W-1:1] == '0);
  end

  rma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl)
  );

  // Stage 0: capture the beat
  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      itm_s0_r  <= lk;
      act_s0_r  <= in_ch.action;
      zero_s0_r <= lk_zero;
    end
  end

  // Stage 1: add, subtract and lift finish here; multiply and reduce are tagged
  assign sum   = {1'b0, itm_s0_r.a} + {1'b0, itm_s0_r.b};
  assign sum_q = rma_pkg::word3_t'(itm_s0_r.a) + rma_pkg::word3_t'(itm_s0_r.b)
               - rma_pkg::word3_t'(itm_s0_r.q);
  assign diff  = {1'b0, itm_s0_r.a} - {1'b0, itm_s0_r.b};

  always_comb begin
    side_nxt = '0;
    sel_nxt  = SEL_SIDE;
    if (!zero_s0_r) begin
      case (act_s0_r)
        rma_pkg::ACT_ADD: begin
          side_nxt = sum_q[rma_pkg::DATA_W+1] ? sum[rma_pkg::DATA_W-1:0]
                                              : sum_q[rma_pkg::DATA_W-1:0];
        end
        rma_pkg::ACT_SUB: begin
          side_nxt = diff[rma_pkg::DATA_W] ? itm_s0_r.a + itm_s0_r.q - itm_s0_r.b
                                           : diff[rma_pkg::DATA_W-1:0];
        end
        rma_pkg::ACT_MUL: begin
          sel_nxt = SEL_MUL;
        end
        rma_pkg::ACT_RED: begin
          sel_nxt = SEL_RED;
        end
        rma_pkg::ACT_LIFT: begin
          side_nxt = itm_s0_r.a[rma_pkg::DATA_W-1] ? itm_s0_r.a + itm_s0_r.q : itm_s0_r.a;
        end
        default: begin
          side_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      res_r[1] <= side_nxt;
      sel_r[1] <= sel_nxt;
    end
  end

  // Carry results down the pipe; take the Barrett result once it is ready
  for (genvar j = 2; j <= LAST; j++) begin : g_carry
    always_ff @(posedge clk) begin
      if (ctl.en[j]) begin
        if (j == rma_pkg::MUL_STAGES + 1 && sel_r[j-1] == SEL_MUL) begin
          res_r[j] <= mul_res;
          sel_r[j] <= SEL_SIDE;
        end else begin
          res_r[j] <= res_r[j-1];
          sel_r[j] <= sel_r[j-1];
        end
      end
    end
  end

  rma_barrett u_barrett (
    .clk     (clk),
    .en      (ctl.en),
    .item    (itm_s0_r),
    .mul_res (mul_res)
  );

  rma_div u_div (
    .clk  (clk),
    .en   (ctl.en),
    .item (itm_s0_r),
    .rem  (rem)
  );

  assign in_ch.ready    = ctl.en[0];
  assign out_ch.valid   = ctl.last_valid;
  assign out_ch.residue = (sel_r[LAST] == SEL_RED) ? rem : res_r[LAST];

endmodule

// ----- design/rma_checker.sv -----
module rma_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rma_pkg::DATA_W-1:0]  residue
);

  // Hold a result beat until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // Hold the residue of a stalled beat
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(residue))
    else $error("residue changed while stalled");

  // Empty the pipe on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat after reset");

  // A draining output never blocks the input side
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // An input beat offered while the output stage is empty is taken
  a_empty_take: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_valid |-> in_ready)
    else $error("input refused with an empty output stage");

endmodule

bind rns_modular_elementwise_alu_core rma_checker u_rma_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .residue   (out_ch.residue)
);
